// ===== hdl/sliding_window_median_unit_assert.svh =====
// Assertion macros used by the checker file of the median unit
`ifndef SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SWMU_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("swmu assertion failed");

// next-cycle implication, disabled while reset is low
`define SWMU_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("swmu assertion failed");

`endif

// ===== hdl/swmu_pkg.sv =====
// Types and constants of the sliding window median unit
package swmu_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_WIDTH = 32;
  localparam int MEDIAN_WIDTH = SAMPLE_WIDTH + 1;
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W        = $clog2(MAX_WINDOW);
  localparam int CFG_W        = 5;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [MEDIAN_WIDTH-1:0] median_t;
  typedef logic [CNT_W-1:0]               cnt_t;
  typedef logic [IDX_W-1:0]               idx_t;

endpackage

// ===== hdl/sliding_window_median_unit.sv =====
// Sliding window median unit: top level
//
// Input channel: sample_i and start_of_stream_i, qualified by in_valid_i; the
// unit holds off the sender with in_stall_o. An item is taken at a rising edge
// with in_valid_i high and in_stall_o low. start_of_stream_i empties the
// window before that item's sample enters.
// Output channel: median_doubled_o (twice the median, one fraction bit) with
// out_valid_o; the receiver holds it with out_stall_i.
// Configuration: cfg_we_i writes cfg_wdata_i as the window size K (0 acts as
// 1, above 16 acts as 16) and empties the window. Write only while idle.
// The first K-1 items of a stream give no result; every later item gives one.
// The accepting edge registers the sorted window and emit_q; the median then
// goes to the output register once that register is not stalled. One item
// per cycle is taken while in_stall_o is low: the sorted window is updated by
// one pass of parallel compares; median pick and add run in the next stage.
// Reset clears the window and sets K to 3; no result is pending after reset.
// A stalled receiver holds the output register; one more result may wait in
// the pick stage, and only then is in_stall_o raised.
module sliding_window_median_unit
  import swmu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    start_of_stream_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [MEDIAN_WIDTH-1:0] median_doubled_o
);

  logic [CFG_W-1:0] window_size_q;
  cnt_t             fill_q, fill_d;
  idx_t             oldest_q, oldest_d;
  logic             emit_q, emit_d;
  logic             out_valid_q;
  median_t          median_q, median_d;
  sample_t          age_q    [MAX_WINDOW];
  sample_t          sorted_q [MAX_WINDOW];
  sample_t          sorted_d [MAX_WINDOW];

  cnt_t    k_size;
  logic    clr;
  cnt_t    fill_eff;
  idx_t    ptr_eff;
  logic    full;
  sample_t old_val;
  cnt_t    keep_n;
  idx_t    wr_idx;
  cnt_t    ptr_inc;
  cnt_t    fill_inc;
  logic    new_emit;
  logic    b_ready;
  logic    in_acc;

  logic [MAX_WINDOW-1:0] le;
  logic [MAX_WINDOW-1:0] le_nxt;
  logic [MAX_WINDOW-1:0] match;
  logic [MAX_WINDOW-1:0] shifted;
  logic [MAX_WINDOW-1:0] rem_le;
  logic [MAX_WINDOW-1:0] lev;
  logic [MAX_WINDOW-1:0] lev_prev;
  sample_t rem      [MAX_WINDOW];
  sample_t rem_nxt  [MAX_WINDOW];
  sample_t rem_prev [MAX_WINDOW];

  idx_t    mid_idx, lo_idx;
  sample_t lo_val, hi_val;

  always_comb begin
    if (window_size_q == '0) begin
      k_size = CNT_W'(1);
    end else if (window_size_q > CFG_W'(MAX_WINDOW)) begin
      k_size = CNT_W'(MAX_WINDOW);
    end else begin
      k_size = CNT_W'(window_size_q);
    end
  end

  assign b_ready    = !out_valid_q || !out_stall_i;
  assign in_stall_o = emit_q && !b_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    logic acc;
    clr      = start_of_stream_i || (fill_q > k_size);
    fill_eff = clr ? '0 : fill_q;
    ptr_eff  = clr ? '0 : oldest_q;
    full     = (fill_eff == k_size);
    old_val  = age_q[ptr_eff];
    keep_n   = full ? k_size - CNT_W'(1) : fill_eff;

    for (int j = 0; j < MAX_WINDOW; j++) begin
      le[j]    = (sorted_q[j] <= sample_i);
      match[j] = full && (CNT_W'(j) < k_size) && (sorted_q[j] == old_val);
    end

    acc = 1'b0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      acc        = acc | match[j];
      shifted[j] = acc;
    end

    for (int j = 0; j < MAX_WINDOW - 1; j++) begin
      rem_nxt[j] = sorted_q[j+1];
      le_nxt[j]  = le[j+1];
    end
    rem_nxt[MAX_WINDOW-1] = sorted_q[MAX_WINDOW-1];
    le_nxt[MAX_WINDOW-1]  = le[MAX_WINDOW-1];

    for (int j = 0; j < MAX_WINDOW; j++) begin
      rem[j]    = shifted[j] ? rem_nxt[j] : sorted_q[j];
      rem_le[j] = shifted[j] ? le_nxt[j] : le[j];
      lev[j]    = rem_le[j] && (CNT_W'(j) < keep_n);
    end

    lev_prev[0] = 1'b1;
    rem_prev[0] = sample_i;
    for (int j = 1; j < MAX_WINDOW; j++) begin
      lev_prev[j] = lev[j-1];
      rem_prev[j] = rem[j-1];
    end

    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (lev[j]) begin
        sorted_d[j] = rem[j];
      end else if (lev_prev[j]) begin
        sorted_d[j] = sample_i;
      end else begin
        sorted_d[j] = rem_prev[j];
      end
    end

    wr_idx   = full ? ptr_eff : fill_eff[IDX_W-1:0];
    ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
    fill_inc = fill_eff + CNT_W'(1);
    if (full) begin
      fill_d   = fill_eff;
      oldest_d = (ptr_inc == k_size) ? '0 : ptr_inc[IDX_W-1:0];
      new_emit = 1'b1;
    end else begin
      fill_d   = fill_inc;
      oldest_d = '0;
      new_emit = (fill_inc == k_size);
    end
  end

  always_comb begin
    mid_idx = k_size[IDX_W:1];
    lo_idx  = k_size[0] ? mid_idx : mid_idx - IDX_W'(1);
    lo_val  = sorted_q[lo_idx];
    hi_val  = sorted_q[mid_idx];
    median_d = MEDIAN_WIDTH'(lo_val) + MEDIAN_WIDTH'(hi_val);
  end

  always_comb begin
    if (in_acc) begin
      emit_d = new_emit;
    end else if (b_ready) begin
      emit_d = 1'b0;
    end else begin
      emit_d = emit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RESET;
      fill_q        <= '0;
      oldest_q      <= '0;
      emit_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      emit_q <= emit_d;
      if (b_ready) begin
        out_valid_q <= emit_q;
      end
      if (cfg_we_i) begin
        window_size_q <= cfg_wdata_i;
        fill_q        <= '0;
        oldest_q      <= '0;
      end else if (in_acc) begin
        fill_q   <= fill_d;
        oldest_q <= oldest_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      age_q[wr_idx] <= sample_i;
      sorted_q      <= sorted_d;
    end
    if (b_ready && emit_q) begin
      median_q <= median_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;

endmodule

// ===== hdl/swmu_checker.sv =====
// Port-level checker for the sliding window median unit, with its bind
`include "sliding_window_median_unit_assert.svh"

module swmu_checker
  import swmu_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [MEDIAN_WIDTH-1:0] median_doubled_o
);

  // hold a stalled result
  `SWMU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(median_doubled_o))

  // stall input only behind a blocked output
  `SWMU_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a fresh result follows an item taken earlier
  `SWMU_ASSERT_IMP(a_result_source, clk_i, rst_ni, $rose(out_valid_o),
                   $past(in_valid_i && !in_stall_o, 2))

endmodule

bind sliding_window_median_unit swmu_checker u_swmu_checker (.*);
